/* rtl/mwrl_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the multi-window rate limiter.
// No dependencies; all other files but mwrl_ram import this package.
package mwrl_pkg;

  localparam int T_W         = 48;
  localparam int DUR_W       = 32;
  localparam int MCNT_W      = 6;
  localparam int WIN_USE_W   = 2;
  localparam int NWIN        = 3;
  localparam int WIN_IDX_W   = 2;
  localparam int MAX_WINDOWS = 3;
  localparam int LOG_DEPTH   = 64;
  localparam int PTR_W       = $clog2(LOG_DEPTH);
  localparam int CNT_W       = $clog2(LOG_DEPTH + 1);
  localparam int FUNC_W      = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TRY   = 2'd0,
    FUNC_BLOCK = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIN_USE = 3'd0,
    CFG_DUR0    = 3'd1,
    CFG_CNT0    = 3'd2,
    CFG_DUR1    = 3'd3,
    CFG_CNT1    = 3'd4,
    CFG_DUR2    = 3'd5,
    CFG_CNT2    = 3'd6
  } cfg_idx_t;

  typedef enum logic {
    ALU_SUB     = 1'b0,
    ALU_ADD_SAT = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t        op;
    logic [T_W-1:0] a;
    logic [T_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [T_W-1:0] value;
    logic           borrow;
  } alu_res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_BLOCK_MAX,
    S_PRUNE_SETUP,
    S_PRUNE_WALK,
    S_CLEANUP_SET,
    S_SLOT_CHECK,
    S_WIN_SETUP,
    S_WIN_WALK,
    S_WIN_DECIDE,
    S_LOG
  } state_t;

endpackage

/* rtl/mwrl_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mwrl_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/mwrl_alu.sv */
`timescale 1ns / 1ps
// Shared 48-bit arithmetic unit: subtract with borrow, or saturating add.
// Depends on mwrl_pkg for the request and result types.
module mwrl_alu (
  input  mwrl_pkg::alu_req_t req,
  output mwrl_pkg::alu_res_t res
);
  import mwrl_pkg::*;

  // One adder serves both operations; subtraction adds the inverted operand.
  logic           is_sub;
  logic [T_W-1:0] b_op;
  logic [T_W:0]   sum;

  assign is_sub = (req.op == ALU_SUB);
  assign b_op   = is_sub ? ~req.b : req.b;
  assign sum    = {1'b0, req.a} + {1'b0, b_op} + {{T_W{1'b0}}, is_sub};

  always_comb begin
    case (req.op)
      ALU_ADD_SAT: begin
        res.value  = sum[T_W] ? {T_W{1'b1}} : sum[T_W-1:0];
        res.borrow = 1'b0;
      end
      default: begin
        res.value  = sum[T_W-1:0];
        res.borrow = ~sum[T_W];
      end
    endcase
  end

endmodule

/* rtl/multi_window_rate_limiter.sv */
`timescale 1ns / 1ps
// Multi-window sliding-window-log rate limiter, top level.
// Depends on mwrl_pkg, mwrl_ram (request log) and mwrl_alu (shared arithmetic).
//
// Usage:
// A transaction is taken at a rising edge where start is high and busy is low.
// in_func selects try (0), block (1) or clear (2); in_now_ms is the current
// time and in_block_ms the blocking time of a block transaction. Every
// transaction yields exactly one result, shown for one cycle with out_valid:
// out_granted, out_next_slot_ms and out_log_fill. The receiver cannot stall,
// so it must take the result in the cycle out_valid is high.
// Clear, unused codes and a try that is granted on an empty log or with no
// window enabled end at the dispatch step; block goes on to a step that keeps
// the later of the old next slot and its own end time. A full try walks the
// log in pruning and once per enabled window in counting, each walk at most
// the log fill (64) entries; the single read port of the log memory and the
// shared adder see one log entry per cycle.
// busy stays high until the result has been produced.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata; the
// user must write them only while idle, which the block does not enforce. A
// write to any defined register index clears the next-slot and cleanup times.
// Reset empties the log, zeroes both times and all configuration registers.
module multi_window_rate_limiter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [mwrl_pkg::FUNC_W-1:0]         in_func,
  input  logic [mwrl_pkg::T_W-1:0]            in_now_ms,
  input  logic [mwrl_pkg::DUR_W-1:0]          in_block_ms,
  output logic                                out_valid,
  output logic                                out_granted,
  output logic [mwrl_pkg::T_W-1:0]            out_next_slot_ms,
  output logic [mwrl_pkg::CNT_W-1:0]          out_log_fill,
  input  logic                                cfg_we,
  input  logic [mwrl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mwrl_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import mwrl_pkg::*;

  // Log slot i (0 is oldest) lives at head + i, wrapped at the log depth.
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - PTR_W){1'b0}}, base} + {1'b0, off};
    if (sum >= (CNT_W + 1)'(LOG_DEPTH)) begin
      sum = sum - (CNT_W + 1)'(LOG_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  // Configuration registers.
  logic [WIN_USE_W-1:0] win_use_r;
  logic [DUR_W-1:0]     dur_r [NWIN];
  logic [MCNT_W-1:0]    mcnt_r [NWIN];

  // Sequencer and limiter state.
  state_t             state_r, state_nxt;
  logic [FUNC_W-1:0]  func_r, func_nxt;
  logic [T_W-1:0]     now_r, now_nxt;
  logic [DUR_W-1:0]   blk_r, blk_nxt;
  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [T_W-1:0]     next_slot_r, next_slot_nxt;
  logic [T_W-1:0]     next_cleanup_r, next_cleanup_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   inside_r, inside_nxt;
  logic [T_W-1:0]     ref_r, ref_nxt;
  logic               flag_r, flag_nxt;
  logic [T_W-1:0]     keep_r, keep_nxt;
  logic [WIN_IDX_W-1:0] win_r, win_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_granted_r, out_granted_nxt;

  // Log memory ports.
  logic               ram_we;
  logic [PTR_W-1:0]   ram_waddr;
  logic [CNT_W-1:0]   rd_idx;
  logic [PTR_W-1:0]   ram_raddr;
  logic [T_W-1:0]     ram_rdata;

  // Shared arithmetic unit.
  alu_req_t           alu_req;
  alu_res_t           alu_res;

  logic                 accept;
  logic [WIN_USE_W-1:0] n_win;
  logic [WIN_IDX_W-1:0] last_win;
  logic [T_W-1:0]       longest;
  logic [T_W-1:0]       cur_dur;

  assign accept   = start && !busy;
  assign busy     = (state_r != S_IDLE);
  assign n_win    = (win_use_r > WIN_USE_W'(MAX_WINDOWS)) ? WIN_USE_W'(MAX_WINDOWS)
                                                         : win_use_r;
  assign last_win = WIN_IDX_W'(n_win - 1'b1);
  assign longest  = {{(T_W - DUR_W){1'b0}}, dur_r[last_win]};
  assign cur_dur  = {{(T_W - DUR_W){1'b0}}, dur_r[win_r]};

  assign ram_raddr = wrap_add(head_r, rd_idx);

  mwrl_ram #(
    .WIDTH(T_W),
    .DEPTH(LOG_DEPTH)
  ) u_log_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(now_r),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  mwrl_alu u_alu (
    .req(alu_req),
    .res(alu_res)
  );

  // Operand selection for the shared unit, one operation per sequencer step.
  always_comb begin
    alu_req.op = ALU_SUB;
    alu_req.a  = now_r;
    alu_req.b  = next_slot_r;
    case (state_r)
      S_DISPATCH: begin
        if (func_r == FUNC_BLOCK) begin
          alu_req.op = ALU_ADD_SAT;
          alu_req.b  = {{(T_W - DUR_W){1'b0}}, blk_r};
        end else begin
          alu_req.b = next_cleanup_r;
        end
      end
      S_BLOCK_MAX: begin
        alu_req.a = next_slot_r;
        alu_req.b = keep_r;
      end
      S_PRUNE_SETUP: begin
        alu_req.b = longest;
      end
      S_PRUNE_WALK: begin
        alu_req.a = ref_r;
        alu_req.b = ram_rdata;
      end
      S_CLEANUP_SET: begin
        alu_req.op = ALU_ADD_SAT;
        alu_req.a  = keep_r;
        alu_req.b  = longest;
      end
      S_WIN_SETUP: begin
        alu_req.b = cur_dur;
      end
      S_WIN_WALK: begin
        alu_req.a = ram_rdata;
        alu_req.b = ref_r;
      end
      S_WIN_DECIDE: begin
        alu_req.op = ALU_ADD_SAT;
        alu_req.a  = (inside_r == '0) ? now_r : keep_r;
        alu_req.b  = cur_dur;
      end
      default: begin
        alu_req.op = ALU_SUB;
      end
    endcase
  end

  // Next state and data path control.
  always_comb begin
    state_nxt        = state_r;
    func_nxt         = func_r;
    now_nxt          = now_r;
    blk_nxt          = blk_r;
    head_nxt         = head_r;
    count_nxt        = count_r;
    next_slot_nxt    = next_slot_r;
    next_cleanup_nxt = next_cleanup_r;
    idx_nxt          = idx_r;
    inside_nxt       = inside_r;
    ref_nxt          = ref_r;
    flag_nxt         = flag_r;
    keep_nxt         = keep_r;
    win_nxt          = win_r;
    out_valid_nxt    = 1'b0;
    out_granted_nxt  = out_granted_r;
    ram_we           = 1'b0;
    ram_waddr        = head_r;
    rd_idx           = idx_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          func_nxt  = in_func;
          now_nxt   = in_now_ms;
          blk_nxt   = in_block_ms;
          state_nxt = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        case (func_r)
          FUNC_TRY: begin
            if (n_win == '0) begin
              out_valid_nxt   = 1'b1;
              out_granted_nxt = 1'b1;
              state_nxt       = S_IDLE;
            end else if (count_r == '0) begin
              // An empty log always grants and logs, even while blocked.
              ram_we          = 1'b1;
              ram_waddr       = head_r;
              count_nxt       = CNT_W'(1);
              out_valid_nxt   = 1'b1;
              out_granted_nxt = 1'b1;
              state_nxt       = S_IDLE;
            end else if (!alu_res.borrow) begin
              state_nxt = S_PRUNE_SETUP;
            end else begin
              state_nxt = S_SLOT_CHECK;
            end
          end
          FUNC_BLOCK: begin
            keep_nxt  = alu_res.value;
            state_nxt = S_BLOCK_MAX;
          end
          FUNC_CLEAR: begin
            count_nxt        = '0;
            next_slot_nxt    = '0;
            next_cleanup_nxt = '0;
            out_valid_nxt    = 1'b1;
            out_granted_nxt  = 1'b0;
            state_nxt        = S_IDLE;
          end
          default: begin
            out_valid_nxt   = 1'b1;
            out_granted_nxt = 1'b0;
            state_nxt       = S_IDLE;
          end
        endcase
      end

      S_BLOCK_MAX: begin
        if (alu_res.borrow) begin
          next_slot_nxt = keep_r;
        end
        out_valid_nxt   = 1'b1;
        out_granted_nxt = 1'b0;
        state_nxt       = S_IDLE;
      end

      S_PRUNE_SETUP: begin
        // Entries at or below now minus the longest window expire, but only
        // when that difference does not go negative.
        flag_nxt  = !alu_res.borrow;
        ref_nxt   = alu_res.value;
        idx_nxt   = '0;
        rd_idx    = '0;
        state_nxt = S_PRUNE_WALK;
      end

      S_PRUNE_WALK: begin
        if (flag_r && !alu_res.borrow) begin
          if (idx_r + 1'b1 == count_r) begin
            count_nxt = '0;
            keep_nxt  = now_r;
            state_nxt = S_CLEANUP_SET;
          end else begin
            idx_nxt = idx_r + 1'b1;
            rd_idx  = idx_r + 1'b1;
          end
        end else begin
          keep_nxt  = ram_rdata;
          head_nxt  = wrap_add(head_r, idx_r);
          count_nxt = count_r - idx_r;
          state_nxt = S_CLEANUP_SET;
        end
      end

      S_CLEANUP_SET: begin
        next_cleanup_nxt = alu_res.value;
        state_nxt        = S_SLOT_CHECK;
      end

      S_SLOT_CHECK: begin
        if (alu_res.borrow) begin
          out_valid_nxt   = 1'b1;
          out_granted_nxt = 1'b0;
          state_nxt       = S_IDLE;
        end else begin
          win_nxt   = last_win;
          state_nxt = S_WIN_SETUP;
        end
      end

      S_WIN_SETUP: begin
        // A window reaching back before time zero holds every entry.
        flag_nxt   = alu_res.borrow;
        ref_nxt    = alu_res.value;
        inside_nxt = '0;
        idx_nxt    = count_r - 1'b1;
        rd_idx     = count_r - 1'b1;
        state_nxt  = (count_r == '0) ? S_WIN_DECIDE : S_WIN_WALK;
      end

      S_WIN_WALK: begin
        if (flag_r || !alu_res.borrow) begin
          inside_nxt = inside_r + 1'b1;
          keep_nxt   = ram_rdata;
          if (idx_r == '0) begin
            state_nxt = S_WIN_DECIDE;
          end else begin
            idx_nxt = idx_r - 1'b1;
            rd_idx  = idx_r - 1'b1;
          end
        end else begin
          state_nxt = S_WIN_DECIDE;
        end
      end

      S_WIN_DECIDE: begin
        if (inside_r >= {{(CNT_W - MCNT_W){1'b0}}, mcnt_r[win_r]}) begin
          next_slot_nxt   = alu_res.value;
          out_valid_nxt   = 1'b1;
          out_granted_nxt = 1'b0;
          state_nxt       = S_IDLE;
        end else if (win_r == '0) begin
          state_nxt = S_LOG;
        end else begin
          win_nxt   = win_r - 1'b1;
          state_nxt = S_WIN_SETUP;
        end
      end

      S_LOG: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (count_r == CNT_W'(LOG_DEPTH)) begin
          out_granted_nxt = 1'b0;
        end else begin
          ram_we          = 1'b1;
          ram_waddr       = wrap_add(head_r, count_r);
          count_nxt       = count_r + 1'b1;
          out_granted_nxt = 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A write to any defined register restarts both time marks; a write to
    // the unused index changes nothing.
    if (cfg_we && (cfg_index <= CFG_CNT2)) begin
      next_slot_nxt    = '0;
      next_cleanup_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      head_r         <= '0;
      count_r        <= '0;
      next_slot_r    <= '0;
      next_cleanup_r <= '0;
      out_valid_r    <= 1'b0;
      out_granted_r  <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      head_r         <= head_nxt;
      count_r        <= count_nxt;
      next_slot_r    <= next_slot_nxt;
      next_cleanup_r <= next_cleanup_nxt;
      out_valid_r    <= out_valid_nxt;
      out_granted_r  <= out_granted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r   <= func_nxt;
    now_r    <= now_nxt;
    blk_r    <= blk_nxt;
    idx_r    <= idx_nxt;
    inside_r <= inside_nxt;
    ref_r    <= ref_nxt;
    flag_r   <= flag_nxt;
    keep_r   <= keep_nxt;
    win_r    <= win_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_use_r <= '0;
      for (int i = 0; i < NWIN; i++) begin
        dur_r[i]  <= '0;
        mcnt_r[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIN_USE: win_use_r <= cfg_wdata[WIN_USE_W-1:0];
        CFG_DUR0:    dur_r[0]  <= cfg_wdata[DUR_W-1:0];
        CFG_CNT0:    mcnt_r[0] <= cfg_wdata[MCNT_W-1:0];
        CFG_DUR1:    dur_r[1]  <= cfg_wdata[DUR_W-1:0];
        CFG_CNT1:    mcnt_r[1] <= cfg_wdata[MCNT_W-1:0];
        CFG_DUR2:    dur_r[2]  <= cfg_wdata[DUR_W-1:0];
        CFG_CNT2:    mcnt_r[2] <= cfg_wdata[MCNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_granted      = out_granted_r;
  assign out_next_slot_ms = next_slot_r;
  assign out_log_fill     = count_r;

  // The result strobe only appears once the sequencer is back in idle.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result strobe while sequencer busy");

  // The log fill never exceeds the log depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(LOG_DEPTH))
    else $error("log fill beyond depth");

  // An accepted transaction makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("transaction accepted but block not busy");

  // Only a try transaction can be granted.
  a_grant_try: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_granted_r) |-> (func_r == FUNC_TRY))
    else $error("grant on a non-try transaction");

endmodule

/* test/tb_multi_window_rate_limiter.sv */
`timescale 1ns / 1ps
// Self-checking testbench for multi_window_rate_limiter: a queue-fed driver, a result
// monitor and a behavioral predictor of the request log, next-slot and cleanup timers.
// Depends on mwrl_pkg and the multi_window_rate_limiter RTL; reads no files.
module tb_multi_window_rate_limiter;
  import mwrl_pkg::*;

  // The slowest legal run is about 1300 transactions, each at the worst-case busy
  // time, plus the longest idle gaps. The limit below is several times that figure.
  localparam int CYCLE_LIMIT     = 3_000_000;
  localparam int MAX_REPORTS     = 60;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 100;

  // The function field is two bits wide; code 3 is not an operation and must leave
  // the state alone.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam logic [T_W-1:0]    T_MAX       = '1;
  localparam logic [DUR_W-1:0]  DUR_MAX     = '1;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [T_W-1:0]    now_ms;
    logic [DUR_W-1:0]  block_ms;
  } limiter_req_t;

  typedef struct packed {
    logic             granted;
    logic [T_W-1:0]   next_slot_ms;
    logic [CNT_W-1:0] log_fill;
  } verdict_t;

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  start       = 1'b0;
  logic                  busy;
  logic [FUNC_W-1:0]     in_func     = '0;
  logic [T_W-1:0]        in_now_ms   = '0;
  logic [DUR_W-1:0]      in_block_ms = '0;
  logic                  out_valid;
  logic                  out_granted;
  logic [T_W-1:0]        out_next_slot_ms;
  logic [CNT_W-1:0]      out_log_fill;
  logic                  cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata   = '0;

  multi_window_rate_limiter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_now_ms        (in_now_ms),
    .in_block_ms      (in_block_ms),
    .out_valid        (out_valid),
    .out_granted      (out_granted),
    .out_next_slot_ms (out_next_slot_ms),
    .out_log_fill     (out_log_fill),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // Predictor copy of the limiter: configuration, request history and both timers.
  logic [WIN_USE_W-1:0] win_use = '0;
  logic [DUR_W-1:0]     win_len [NWIN];
  logic [MCNT_W-1:0]    win_cap [NWIN];
  logic [T_W-1:0]       hist [LOG_DEPTH];
  int                   hist_len   = 0;
  logic [T_W-1:0]       slot_ms    = '0;
  logic [T_W-1:0]       cleanup_ms = '0;

  limiter_req_t request_q [$];   // transactions waiting to be driven
  verdict_t     verdict_q [$];   // predicted results, oldest first
  limiter_req_t cur_req;
  int           in_flight = 0;   // queued transactions whose result has not been seen
  int           err_cnt   = 0;
  int           gap_left  = 0;
  int           cycle_cnt = 0;
  bit           idle_on   = 1'b1;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Time sums in the limiter clamp at the top of the 48-bit range instead of wrapping.
  function automatic logic [T_W-1:0] add_sat(logic [T_W-1:0] a, logic [T_W-1:0] b);
    logic [T_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[T_W] ? T_MAX : s[T_W-1:0];
  endfunction

  // A try transaction: prune when cleanup is due, honor the next slot, then scan the
  // windows from the last enabled one down to window 0. Returns the grant decision.
  function automatic logic try_admit(logic [T_W-1:0] now);
    int             n;
    int             drop;
    int             in_win;
    int             i;
    logic [T_W-1:0] longest;
    logic [T_W-1:0] expires;
    logic [T_W-1:0] wstart;
    logic           all_in;
    n = (win_use > MAX_WINDOWS) ? MAX_WINDOWS : win_use;
    if (n == 0) return 1'b1;
    // An empty log always takes the request, even while the next slot lies ahead.
    if (hist_len == 0) begin
      hist[0]  = now;
      hist_len = 1;
      return 1'b1;
    end
    if (cleanup_ms <= now) begin
      longest = win_len[n-1];
      drop    = 0;
      // When the longest window reaches back past time zero nothing can expire.
      if (longest <= now) begin
        expires = now - longest;
        while (drop < hist_len && hist[drop] <= expires) drop++;
      end
      for (i = 0; i < hist_len - drop; i++) hist[i] = hist[i + drop];
      hist_len   = hist_len - drop;
      cleanup_ms = add_sat((hist_len > 0) ? hist[0] : now, longest);
    end
    if (slot_ms > now) return 1'b0;
    for (int w = n - 1; w >= 0; w--) begin
      all_in = win_len[w] > now;
      wstart = all_in ? '0 : now - win_len[w];
      in_win = 0;
      i      = hist_len;
      // Counting runs from the newest entry back to the first one before the window.
      while (i > 0 && (all_in || hist[i-1] >= wstart)) begin
        in_win++;
        i--;
      end
      if (in_win >= win_cap[w]) begin
        slot_ms = add_sat((in_win == 0) ? now : hist[hist_len - in_win], win_len[w]);
        return 1'b0;
      end
    end
    // Every window has room but the log itself is full: refuse without logging.
    if (hist_len >= LOG_DEPTH) return 1'b0;
    hist[hist_len] = now;
    hist_len++;
    return 1'b1;
  endfunction

  function automatic verdict_t limiter_step(limiter_req_t rq);
    verdict_t       v;
    logic [T_W-1:0] until_ms;
    v.granted = 1'b0;
    case (rq.func)
      FUNC_TRY: v.granted = try_admit(rq.now_ms);
      FUNC_BLOCK: begin
        until_ms = add_sat(rq.now_ms, rq.block_ms);
        if (until_ms > slot_ms) slot_ms = until_ms;
      end
      FUNC_CLEAR: begin
        hist_len   = 0;
        slot_ms    = '0;
        cleanup_ms = '0;
      end
      default: ;
    endcase
    v.next_slot_ms = slot_ms;
    v.log_fill     = hist_len[CNT_W-1:0];
    return v;
  endfunction

  // Any register write also zeroes both timers; the log is left as it is.
  function automatic void apply_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_WIN_USE: win_use    = val[WIN_USE_W-1:0];
      CFG_DUR0:    win_len[0] = val[DUR_W-1:0];
      CFG_CNT0:    win_cap[0] = val[MCNT_W-1:0];
      CFG_DUR1:    win_len[1] = val[DUR_W-1:0];
      CFG_CNT1:    win_cap[1] = val[MCNT_W-1:0];
      CFG_DUR2:    win_len[2] = val[DUR_W-1:0];
      CFG_CNT2:    win_cap[2] = val[MCNT_W-1:0];
      default: ;
    endcase
    slot_ms    = '0;
    cleanup_ms = '0;
  endfunction

  function automatic logic [T_W-1:0] rand_time();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[T_W-1:0];
  endfunction

  // Mostly back-to-back or short gaps, now and then a long pause. Phases with idling
  // switched off give stretches of full-rate traffic.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 40) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 40);
    return $urandom_range(100, 400);
  endfunction

  function automatic void report_field(string what, logic [T_W-1:0] want, logic [T_W-1:0] got);
    err_cnt++;
    // Reporting stops after a while so a badly broken build cannot flood the log.
    if (err_cnt <= MAX_REPORTS)
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
  endfunction

  task automatic queue_req(logic [FUNC_W-1:0] f, logic [T_W-1:0] now, logic [DUR_W-1:0] blk);
    limiter_req_t rq;
    rq.func     = f;
    rq.now_ms   = now;
    rq.block_ms = blk;
    request_q.insert(request_q.size(), rq);
    in_flight++;
  endtask

  // Register writes go out one per clock; the predictor copy is updated as each one
  // is driven. They are only issued while the limiter is idle.
  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    apply_reg(idx, val);
  endtask

  task automatic end_cfg();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_windows(logic [WIN_USE_W-1:0] n_win,
                                 logic [DUR_W-1:0] d0, logic [MCNT_W-1:0] c0,
                                 logic [DUR_W-1:0] d1, logic [MCNT_W-1:0] c1,
                                 logic [DUR_W-1:0] d2, logic [MCNT_W-1:0] c2);
    write_reg(CFG_WIN_USE, n_win);
    write_reg(CFG_DUR0, d0);
    write_reg(CFG_CNT0, c0);
    write_reg(CFG_DUR1, d1);
    write_reg(CFG_CNT1, c1);
    write_reg(CFG_DUR2, d2);
    write_reg(CFG_CNT2, c2);
    end_cfg();
  endtask

  // Waits until every queued transaction has produced its result and busy has
  // dropped, then leaves a few quiet cycles before the next register write.
  task automatic settle();
    wait (in_flight == 0);
    while (busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Driver. A transaction is taken at an edge where start is high and busy is low;
  // the prediction is made at that same edge, from the values being presented. The
  // next transaction is either presented at once (start stays high) or after a gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) verdict_q.insert(verdict_q.size(), limiter_step(cur_req));
      if (!start || !busy) begin
        if (gap_left > 0) begin
          start    <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (request_q.size() > 0) begin
          cur_req      = request_q.pop_front();
          in_func     <= cur_req.func;
          in_now_ms   <= cur_req.now_ms;
          in_block_ms <= cur_req.block_ms;
          start       <= 1'b1;
          gap_left    <= pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor. Results cannot be held off, so each strobe is taken and checked in the
  // cycle it appears, against the oldest prediction.
  always @(posedge clk) begin : result_check
    verdict_t want;
    if (rst_n && out_valid) begin
      if (verdict_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("%0t ns: result with no transaction pending, expected none, actual %0d/%0d/%0d",
                   $time, out_granted, out_next_slot_ms, out_log_fill);
      end else begin
        want = verdict_q.pop_front();
        in_flight--;
        if (out_granted !== want.granted)
          report_field("granted", want.granted, out_granted);
        if (out_next_slot_ms !== want.next_slot_ms)
          report_field("next_slot_ms", want.next_slot_ms, out_next_slot_ms);
        if (out_log_fill !== want.log_fill)
          report_field("log_fill", want.log_fill, out_log_fill);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int                 adv;
    int                 pick;
    int                 scale_ms;
    logic [WIN_USE_W-1:0] n_win;
    logic [T_W-1:0]     t_ms;
    logic [DUR_W-1:0]   d0, d1, d2;
    logic [MCNT_W-1:0]  c0, c1, c2;
    for (int w = 0; w < NWIN; w++) begin
      win_len[w] = '0;
      win_cap[w] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Out of reset no window is enabled: tries pass without being logged. A block at
    // the top of the time range saturates the next slot; code 3 changes nothing.
    queue_req(FUNC_TRY, '0, DUR_MAX);
    queue_req(FUNC_TRY, T_MAX, '0);
    queue_req(FUNC_BLOCK, T_MAX, DUR_MAX);
    queue_req(FUNC_UNUSED, rand_time(), $urandom);
    queue_req(FUNC_CLEAR, T_MAX, DUR_MAX);
    settle();

    // Three small windows near time zero, where at first every window start lies below zero.
    program_windows(2'd3, 10, 2, 100, 3, 1000, 4);
    queue_req(FUNC_TRY, 5, 0);      // empty log: granted and logged
    queue_req(FUNC_TRY, 6, 0);      // first cleanup pass, nothing expires
    queue_req(FUNC_TRY, 7, 0);      // shortest window full, next slot moves to 15
    queue_req(FUNC_TRY, 8, 0);      // still before the next slot
    queue_req(FUNC_TRY, 15, 0);     // slot reached, shortest window still full
    queue_req(FUNC_TRY, 16, 0);     // oldest entry has left the shortest window
    queue_req(FUNC_TRY, 17, 0);     // middle window full
    queue_req(FUNC_BLOCK, 20, 0);   // zero block time never lowers the slot
    queue_req(FUNC_BLOCK, 100, 500);
    queue_req(FUNC_TRY, 600, 0);
    queue_req(FUNC_TRY, 1100, 0);   // cleanup drops the three oldest entries
    settle();

    // One window of the largest duration that allows nothing: a try at the top of
    // the time range prunes everything and saturates both timers.
    write_reg(CFG_WIN_USE, 1);
    write_reg(CFG_DUR0, DUR_MAX);
    write_reg(CFG_CNT0, 0);
    end_cfg();
    queue_req(FUNC_TRY, T_MAX, $urandom);
    queue_req(FUNC_TRY, T_MAX - 1, $urandom);
    queue_req(FUNC_CLEAR, 0, 0);
    queue_req(FUNC_TRY, 3, $urandom);
    queue_req(FUNC_TRY, 4, $urandom);   // full window holding one entry
    settle();

    // Random phases. Each one programs every register, then runs a stream of tries
    // at a slowly advancing time, mixed with blocks, clears, late arrivals and noise.
    for (int ph = 0; ph < PHASES; ph++) begin
      idle_on = (ph % 4 != 2);
      case ($urandom_range(0, 3))
        0:       scale_ms = 8;
        1:       scale_ms = 60;
        2:       scale_ms = 1000;
        default: scale_ms = 50000;
      endcase
      d0 = $urandom_range(0, scale_ms);
      d1 = d0 + $urandom_range(0, 4 * scale_ms);
      d2 = d1 + $urandom_range(0, 16 * scale_ms);
      // Now and then the windows are unordered or span the full 32-bit range.
      if ($urandom_range(0, 5) == 0) begin
        d0 = $urandom;
        d1 = $urandom;
        d2 = $urandom;
      end
      c0 = $urandom_range(1, 4);
      c1 = c0 + $urandom_range(0, 6);
      c2 = c1 + $urandom_range(0, 12);
      if ($urandom_range(0, 7) == 0) c0 = 0;
      if ($urandom_range(0, 7) == 0) c2 = 63;
      n_win = $urandom_range(1, 3);
      if ($urandom_range(0, 9) == 0) n_win = 0;
      case (ph)
        3: begin
          // One short window that never fills, so only the log size can stop a try.
          n_win = 1;
          d0    = 5;
          c0    = 63;
        end
        7: n_win = 0;
        9: begin
          n_win = 3;
          d0    = 0;
          c0    = 63;
          d2    = DUR_MAX;
          c2    = $urandom_range(0, 63);
        end
        default: ;
      endcase
      program_windows(n_win, d0, c0, d1, c1, d2, c2);

      case ($urandom_range(0, 5))
        0:       t_ms = $urandom_range(0, 20);
        1:       t_ms = T_MAX - $urandom_range(0, 64 * scale_ms);
        2:       t_ms = rand_time();
        default: t_ms = $urandom_range(0, 1 << 24);
      endcase

      // A far-future first entry holds off every cleanup pass, so the entries that
      // follow at early times pile up until the log is full.
      if (ph == 3) begin
        queue_req(FUNC_CLEAR, t_ms, $urandom);
        queue_req(FUNC_TRY, 1000000, $urandom);
        for (int k = 0; k < 70; k++) queue_req(FUNC_TRY, 10 + 2 * k, $urandom);
      end

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 76)
          queue_req(FUNC_TRY, t_ms, $urandom);
        else if (pick < 85)
          queue_req(FUNC_BLOCK, t_ms, $urandom_range(0, 2 * scale_ms));
        else if (pick < 86)
          queue_req(FUNC_BLOCK, t_ms, $urandom);
        else if (pick < 88)
          queue_req(FUNC_CLEAR, t_ms, $urandom);
        else if (pick < 90)
          queue_req(FUNC_UNUSED, rand_time(), $urandom);
        else if (pick < 95)
          queue_req(FUNC_TRY, t_ms - $urandom_range(0, 4 * scale_ms), $urandom);
        else
          queue_req(FUNC_TRY, rand_time(), $urandom);
        adv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8 * scale_ms)
                                          : $urandom_range(0, scale_ms / 2 + 1);
        t_ms = t_ms + adv;
      end
      settle();
    end

    // Tail: a full worst-case try latency of quiet time to catch stray results.
    repeat (300) @(posedge clk);
    if (err_cnt == 0 && verdict_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/mwrl_pkg.sv
rtl/mwrl_ram.sv
rtl/mwrl_alu.sv
rtl/multi_window_rate_limiter.sv
test/tb_multi_window_rate_limiter.sv
